// ----- design/multitouch_slot_event_decoder_macros.svh -----
// Assertion macros for the multitouch slot event decoder.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef MULTITOUCH_SLOT_EVENT_DECODER_MACROS_SVH
`define MULTITOUCH_SLOT_EVENT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSED_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/msed_pkg.sv -----
// Shared types and constants for the multitouch slot event decoder.
// No dependencies; imported by every module of the block.
package msed_pkg;

    localparam logic [4:0] EV_SYN = 5'd0;
    localparam logic [4:0] EV_KEY = 5'd1;
    localparam logic [4:0] EV_ABS = 5'd3;

    localparam logic [9:0] SYN_FRAME_END   = 10'd0;
    localparam logic [9:0] KEY_CONTACT     = 10'd330;
    localparam logic [9:0] ABS_SLOT_SELECT = 10'd47;
    localparam logic [9:0] ABS_MT_POS_X    = 10'd53;
    localparam logic [9:0] ABS_MT_POS_Y    = 10'd54;
    localparam logic [9:0] ABS_MT_TRACK    = 10'd57;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [4:0]  CNT_MAX      = 5'd31;
    localparam int          QUEUE_DEPTH  = 4;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_SETX    = 3'd2,
        OP_SETY    = 3'd3,
        OP_SYNC    = 3'd4,
        OP_KEY     = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_MOVE = 2'd2,
        PH_UP   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        RK_DOWN = 3'd0,
        RK_MOVE = 3'd1,
        RK_UP   = 3'd2,
        RK_ALL  = 3'd3,
        RK_KEY  = 3'd4
    } kind_t;

    typedef struct packed {
        op_t         op;
        logic [51:0] t;
        logic [9:0]  code;
        logic [31:0] arg;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic        xk;
        logic [15:0] x;
        logic        yk;
        logic [15:0] y;
        logic [51:0] press;
        logic [51:0] rel;
        logic [15:0] rx;
        logic [15:0] ry;
        phase_t      phase;
        logic        pending;
    } row_t;

    localparam row_t RESET_ROW = '{
        xk: 1'b0, x: 16'd0, yk: 1'b0, y: 16'd0, press: 52'd0, rel: 52'd0,
        rx: 16'd0, ry: 16'd0, phase: PH_IDLE, pending: 1'b0
    };

endpackage

// ----- design/msed_front.sv -----
// Front end: accepts events, keeps the current slot, works out the event time
// and classifies each event into a queue operation. Depends on msed_pkg.
module msed_front
    import msed_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int SW    = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               event_valid,
    output logic               event_stall,
    input  logic [4:0]         event_type,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    input  logic [31:0]        time_sec,
    input  logic [19:0]        time_usec,
    input  q_stat_t            q_stat,
    output logic               push,
    output qentry_t            push_ent,
    output logic [SW-1:0]      push_slot
);

    logic [SW-1:0] cur_slot_reg;
    logic [SW-1:0] cur_slot_next;
    logic [51:0]   t_us;
    logic [15:0]   coord;
    logic          relevant;
    logic          slot_sel;
    logic          accept;

    assign event_stall = q_stat.full;
    assign accept      = event_valid && !q_stat.full;

    assign t_us = {20'd0, time_sec} * {32'd0, USEC_PER_SEC} + {32'd0, time_usec};

    // Coordinates saturate to the unsigned 16-bit range.
    assign coord = event_value[31] ? 16'd0 :
                   (|event_value[30:16]) ? 16'hFFFF : event_value[15:0];

    assign slot_sel = (event_type == EV_ABS) && (event_code == ABS_SLOT_SELECT) &&
                      !event_value[31] && (event_value[30:0] < 31'(SLOTS));

    always_comb
    begin
        relevant      = 1'b0;
        push_ent.op   = OP_SYNC;
        push_ent.t    = t_us;
        push_ent.code = event_code;
        push_ent.arg  = event_value;
        case (event_type)
            EV_ABS:
            begin
                case (event_code)
                    ABS_MT_TRACK:
                    begin
                        push_ent.op = event_value[31] ? OP_RELEASE : OP_START;
                        relevant    = 1'b1;
                    end
                    ABS_MT_POS_X:
                    begin
                        push_ent.op  = OP_SETX;
                        push_ent.arg = {16'd0, coord};
                        relevant     = 1'b1;
                    end
                    ABS_MT_POS_Y:
                    begin
                        push_ent.op  = OP_SETY;
                        push_ent.arg = {16'd0, coord};
                        relevant     = 1'b1;
                    end
                    default:
                    begin
                        relevant = 1'b0;
                    end
                endcase
            end
            EV_SYN:
            begin
                push_ent.op = OP_SYNC;
                relevant    = (event_code == SYN_FRAME_END);
            end
            EV_KEY:
            begin
                push_ent.op = OP_KEY;
                relevant    = (event_code != KEY_CONTACT);
            end
            default:
            begin
                relevant = 1'b0;
            end
        endcase
    end

    assign push      = accept && relevant;
    assign push_slot = cur_slot_reg;

    always_comb
    begin
        cur_slot_next = cur_slot_reg;
        if (accept && slot_sel)
        begin
            cur_slot_next = event_value[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg <= '0;
        end
        else
        begin
            cur_slot_reg <= cur_slot_next;
        end
    end

endmodule

// ----- design/msed_queue.sv -----
// Short queue between the front end and the slot back end.
// Depends on msed_pkg for the entry and status types.
module msed_queue
    import msed_pkg::*;
#(
    parameter int SW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qentry_t       push_ent,
    input  logic [SW-1:0] push_slot,
    input  logic          pop,
    output qentry_t       head_ent,
    output logic [SW-1:0] head_slot,
    output q_stat_t       q_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    qentry_t       ent_reg  [QUEUE_DEPTH];
    logic [SW-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign q_stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_ent     = ent_reg[rd_ptr_reg];
    assign head_slot    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg]  <= push_ent;
            slot_reg[wr_ptr_reg] <= push_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/msed_back.sv -----
// Back end: slot state memory with read-modify-write, contact count,
// report generation and the output register. Depends on msed_pkg.
module msed_back
    import msed_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int SW    = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  qentry_t            head_ent,
    input  logic [SW-1:0]      head_slot,
    input  q_stat_t            q_stat,
    output logic               pop,
    output logic               report_valid,
    input  logic               report_stall,
    output logic [2:0]         report_kind,
    output logic [3:0]         slot_index,
    output logic [51:0]        time_us,
    output logic [15:0]        x_pos,
    output logic [15:0]        y_pos,
    output logic [9:0]         key_code,
    output logic signed [31:0] key_value,
    output logic               last
);

    typedef enum logic [1:0] {
        ST_FIRST  = 2'b01,
        ST_SECOND = 2'b10
    } bst_t;

    row_t            mem [SLOTS];
    logic [SLOTS-1:0] row_valid_reg;
    row_t            row_rd_reg;
    row_t            row_new;

    logic            b2_valid_reg;
    logic            b2_valid_next;
    qentry_t         b2_ent_reg;
    logic [SW-1:0]   b2_slot_reg;
    bst_t            st_reg;
    bst_t            st_next;
    logic [4:0]      cnt_reg;
    logic [4:0]      cnt_next;

    logic [1:0]      nres;
    kind_t           res_kind;
    logic [51:0]     res_t;
    logic [15:0]     res_x;
    logic [15:0]     res_y;
    logic [9:0]      res_code;
    logic [31:0]     res_val;
    logic [SW+3:0]   slot_wide;

    logic            out_valid_reg;
    logic            out_valid_next;
    kind_t           out_kind_reg;
    logic [3:0]      out_slot_reg;
    logic [51:0]     out_t_reg;
    logic [15:0]     out_x_reg;
    logic [15:0]     out_y_reg;
    logic [9:0]      out_code_reg;
    logic [31:0]     out_val_reg;
    logic            out_last_reg;

    logic            out_free;
    logic            load;
    logic            done;
    logic            we;

    assign slot_wide = {4'd0, b2_slot_reg};

    always_comb
    begin
        row_new  = row_rd_reg;
        cnt_next = cnt_reg;
        nres     = 2'd0;
        res_kind = RK_KEY;
        res_t    = b2_ent_reg.t;
        res_x    = 16'd0;
        res_y    = 16'd0;
        res_code = 10'd0;
        res_val  = 32'd0;
        case (b2_ent_reg.op)
            OP_START:
            begin
                row_new.press   = b2_ent_reg.t;
                row_new.pending = 1'b1;
                if (cnt_reg < CNT_MAX)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_RELEASE:
            begin
                row_new.rel   = b2_ent_reg.t;
                row_new.rx    = row_rd_reg.xk ? row_rd_reg.x : 16'd0;
                row_new.ry    = row_rd_reg.yk ? row_rd_reg.y : 16'd0;
                row_new.phase = PH_UP;
                if (cnt_reg != 5'd0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            OP_SETX:
            begin
                row_new.x  = b2_ent_reg.arg[15:0];
                row_new.xk = 1'b1;
            end
            OP_SETY:
            begin
                row_new.y  = b2_ent_reg.arg[15:0];
                row_new.yk = 1'b1;
            end
            OP_SYNC:
            begin
                if (row_rd_reg.xk && row_rd_reg.yk)
                begin
                    if (row_rd_reg.pending)
                    begin
                        row_new.phase   = PH_DOWN;
                        row_new.pending = 1'b0;
                        nres            = 2'd1;
                        res_kind        = RK_DOWN;
                        res_t           = row_rd_reg.press;
                        res_x           = row_rd_reg.x;
                        res_y           = row_rd_reg.y;
                    end
                    else if (row_rd_reg.phase == PH_UP)
                    begin
                        // An up with no contacts left is followed by an all-released item.
                        nres     = (cnt_reg == 5'd0) ? 2'd2 : 2'd1;
                        res_kind = RK_UP;
                        res_t    = row_rd_reg.rel;
                        res_x    = row_rd_reg.rx;
                        res_y    = row_rd_reg.ry;
                    end
                    else if (row_rd_reg.phase == PH_DOWN || row_rd_reg.phase == PH_MOVE)
                    begin
                        row_new.phase = PH_MOVE;
                        nres          = 2'd1;
                        res_kind      = RK_MOVE;
                        res_x         = row_rd_reg.x;
                        res_y         = row_rd_reg.y;
                    end
                end
            end
            OP_KEY:
            begin
                nres     = 2'd1;
                res_kind = RK_KEY;
                res_code = b2_ent_reg.code;
                res_val  = b2_ent_reg.arg;
            end
            default:
            begin
                nres = 2'd0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || !report_stall;
    assign load     = b2_valid_reg && (nres != 2'd0) && out_free;
    assign done     = b2_valid_reg &&
                      ((nres == 2'd0) ||
                       (out_free && ((st_reg == ST_SECOND) || (nres == 2'd1))));
    assign we       = done;
    assign pop      = !q_stat.empty && (!b2_valid_reg || done);

    always_comb
    begin
        st_next = st_reg;
        if (load && (st_reg == ST_FIRST) && (nres == 2'd2))
        begin
            st_next = ST_SECOND;
        end
        else if (done)
        begin
            st_next = ST_FIRST;
        end
    end

    always_comb
    begin
        b2_valid_next = b2_valid_reg;
        if (pop)
        begin
            b2_valid_next = 1'b1;
        end
        else if (done)
        begin
            b2_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!report_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[b2_slot_reg] <= row_new;
        end
    end

    // A row written in the same cycle as it is read is forwarded; a row never
    // written reads as its reset value.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b2_ent_reg  <= head_ent;
            b2_slot_reg <= head_slot;
            if (we && (b2_slot_reg == head_slot))
            begin
                row_rd_reg <= row_new;
            end
            else if (row_valid_reg[head_slot])
            begin
                row_rd_reg <= mem[head_slot];
            end
            else
            begin
                row_rd_reg <= RESET_ROW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (st_reg == ST_SECOND)
            begin
                out_kind_reg <= RK_ALL;
                out_slot_reg <= 4'd0;
                out_t_reg    <= 52'd0;
                out_x_reg    <= 16'd0;
                out_y_reg    <= 16'd0;
                out_code_reg <= 10'd0;
                out_val_reg  <= 32'd0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_kind_reg <= res_kind;
                out_slot_reg <= (res_kind == RK_KEY) ? 4'd0 : slot_wide[3:0];
                out_t_reg    <= res_t;
                out_x_reg    <= res_x;
                out_y_reg    <= res_y;
                out_code_reg <= res_code;
                out_val_reg  <= res_val;
                out_last_reg <= (nres == 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            b2_valid_reg  <= 1'b0;
            st_reg        <= ST_FIRST;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                row_valid_reg[b2_slot_reg] <= 1'b1;
            end
            if (done)
            begin
                cnt_reg <= cnt_next;
            end
            b2_valid_reg  <= b2_valid_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign report_valid = out_valid_reg;
    assign report_kind  = out_kind_reg;
    assign slot_index   = out_slot_reg;
    assign time_us      = out_t_reg;
    assign x_pos        = out_x_reg;
    assign y_pos        = out_y_reg;
    assign key_code     = out_code_reg;
    assign key_value    = $signed(out_val_reg);
    assign last         = out_last_reg;

endmodule

// ----- design/multitouch_slot_event_decoder.sv -----
// Channel   Handshake                   Payload
// event     event_valid / event_stall   event_type, event_code, event_value,
//                                       time_sec, time_usec
// report    report_valid / report_stall report_kind, slot_index, time_us, x_pos,
//                                       y_pos, key_code, key_value, last
//
// One item is taken per cycle while event_stall is low; the event time multiply sits in the front end.
// An item leaves the queue into the slot row read register; from there the row is
// updated and written back, and any report is loaded into the report register.
// A sync that yields an up and an all-released item holds the back end until both are loaded.
// Reset clears the per-slot valid bits at once; no clearing pass is needed.
// A stalled report side fills the four-entry queue, after which event_stall rises.
`include "multitouch_slot_event_decoder_macros.svh"

module multitouch_slot_event_decoder
    import msed_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               event_valid,
    output logic               event_stall,
    input  logic [4:0]         event_type,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    input  logic [31:0]        time_sec,
    input  logic [19:0]        time_usec,
    output logic               report_valid,
    input  logic               report_stall,
    output logic [2:0]         report_kind,
    output logic [3:0]         slot_index,
    output logic [51:0]        time_us,
    output logic [15:0]        x_pos,
    output logic [15:0]        y_pos,
    output logic [9:0]         key_code,
    output logic signed [31:0] key_value,
    output logic               last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          push;
    logic          pop;
    qentry_t       push_ent;
    qentry_t       head_ent;
    logic [SW-1:0] push_slot;
    logic [SW-1:0] head_slot;
    q_stat_t       q_stat;

    msed_front #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .time_sec    (time_sec),
        .time_usec   (time_usec),
        .q_stat      (q_stat),
        .push        (push),
        .push_ent    (push_ent),
        .push_slot   (push_slot)
    );

    msed_queue #(
        .SW (SW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ent  (push_ent),
        .push_slot (push_slot),
        .pop       (pop),
        .head_ent  (head_ent),
        .head_slot (head_slot),
        .q_stat    (q_stat)
    );

    msed_back #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_ent     (head_ent),
        .head_slot    (head_slot),
        .q_stat       (q_stat),
        .pop          (pop),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report_kind  (report_kind),
        .slot_index   (slot_index),
        .time_us      (time_us),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .key_code     (key_code),
        .key_value    (key_value),
        .last         (last)
    );

    `MSED_ASSERT_HOLDS(a_no_push_when_full, q_stat.full, !push, "push into a full queue")
    `MSED_ASSERT_HOLDS(a_no_pop_when_empty, q_stat.empty, !pop, "pop from an empty queue")
    `MSED_ASSERT_NEXT(a_all_follows_up, report_valid && !report_stall && !last, report_valid && (report_kind == 3'(RK_ALL)) && last, "all-released item missing after up")

endmodule

// ----- bench/touch_report_check.sv -----
// Report checker for the multitouch slot event decoder: watches both channels,
// predicts the reports of every accepted event item and compares them in order.
// Depends on msed_pkg for the event codes, the slot row and the report kinds.
module touch_report_check
    import msed_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               event_valid,
    input  logic               event_stall,
    input  logic [4:0]         event_type,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    input  logic [31:0]        time_sec,
    input  logic [19:0]        time_usec,
    input  logic               report_valid,
    input  logic               report_stall,
    input  logic [2:0]         report_kind,
    input  logic [3:0]         slot_index,
    input  logic [51:0]        time_us,
    input  logic [15:0]        x_pos,
    input  logic [15:0]        y_pos,
    input  logic [9:0]         key_code,
    input  logic signed [31:0] key_value,
    input  logic               last,
    output int                 bad_reports,
    output int                 due_count
);

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [51:0] t;
        logic [15:0] x;
        logic [15:0] y;
        logic [9:0]  kcode;
        logic [31:0] kval;
        logic        last;
    } report_t;

    report_t    due_reports[$];
    row_t       rows [SLOT_COUNT];
    logic [3:0] cur_slot;
    logic [4:0] contacts;

    function automatic logic [15:0] clip_coord(input logic signed [31:0] v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic report_t make_report(input kind_t k, input logic [3:0] s,
                                            input logic [51:0] t, input logic [15:0] x,
                                            input logic [15:0] y, input logic [9:0] kc,
                                            input logic [31:0] kv);
        report_t r;
        r.kind  = k;
        r.slot  = s;
        r.t     = t;
        r.x     = x;
        r.y     = y;
        r.kcode = kc;
        r.kval  = kv;
        r.last  = 1'b0;
        return r;
    endfunction

    // Applies one event item to the slot state and queues the reports it causes.
    task automatic decode_event(input logic [4:0] ty, input logic [9:0] code,
                                input logic signed [31:0] val, input logic [31:0] sec,
                                input logic [19:0] usec);
        logic [51:0] t;
        logic [3:0]  s;
        row_t        r;
        report_t     made [2];
        int          n;
        t = {20'd0, sec} * {32'd0, USEC_PER_SEC} + {32'd0, usec};
        s = cur_slot;
        r = rows[s];
        n = 0;
        if (ty == EV_ABS)
        begin
            if (code == ABS_SLOT_SELECT)
            begin
                if (val >= 0 && val < SLOT_COUNT)
                    cur_slot = val[3:0];
            end
            else if (code == ABS_MT_TRACK)
            begin
                if (val >= 0)
                begin
                    r.press   = t;
                    r.pending = 1'b1;
                    if (contacts < CNT_MAX)
                        contacts = contacts + 5'd1;
                end
                else
                begin
                    r.rel   = t;
                    r.rx    = r.xk ? r.x : 16'd0;
                    r.ry    = r.yk ? r.y : 16'd0;
                    r.phase = PH_UP;
                    if (contacts != 5'd0)
                        contacts = contacts - 5'd1;
                end
            end
            else if (code == ABS_MT_POS_X)
            begin
                r.x  = clip_coord(val);
                r.xk = 1'b1;
            end
            else if (code == ABS_MT_POS_Y)
            begin
                r.y  = clip_coord(val);
                r.yk = 1'b1;
            end
        end
        else if (ty == EV_SYN)
        begin
            if (code == SYN_FRAME_END && r.xk && r.yk)
            begin
                // A pending start wins over any phase the slot was left in.
                if (r.pending)
                begin
                    r.phase   = PH_DOWN;
                    r.pending = 1'b0;
                    made[n]   = make_report(RK_DOWN, s, r.press, r.x, r.y, 10'd0, 32'd0);
                    n++;
                end
                else if (r.phase == PH_UP)
                begin
                    made[n] = make_report(RK_UP, s, r.rel, r.rx, r.ry, 10'd0, 32'd0);
                    n++;
                    if (contacts == 5'd0)
                    begin
                        made[n] = make_report(RK_ALL, 4'd0, 52'd0, 16'd0, 16'd0,
                                              10'd0, 32'd0);
                        n++;
                    end
                end
                else if (r.phase == PH_DOWN || r.phase == PH_MOVE)
                begin
                    r.phase = PH_MOVE;
                    made[n] = make_report(RK_MOVE, s, t, r.x, r.y, 10'd0, 32'd0);
                    n++;
                end
            end
        end
        else if (ty == EV_KEY)
        begin
            if (code != KEY_CONTACT)
            begin
                made[n] = make_report(RK_KEY, 4'd0, t, 16'd0, 16'd0, code, val);
                n++;
            end
        end
        rows[s] = r;
        for (int i = 0; i < n; i++)
        begin
            made[i].last = (i == n - 1);
            due_reports.push_back(made[i]);
        end
    endtask

    task automatic check_report();
        report_t got;
        report_t want;
        got.kind  = kind_t'(report_kind);
        got.slot  = slot_index;
        got.t     = time_us;
        got.x     = x_pos;
        got.y     = y_pos;
        got.kcode = key_code;
        got.kval  = key_value;
        got.last  = last;
        if (due_reports.size() == 0)
        begin
            bad_reports++;
            if (bad_reports <= 10)
                $display("report with nothing due: kind %0d slot %0d t %0d x %0d y %0d",
                         got.kind, got.slot, got.t, got.x, got.y);
        end
        else
        begin
            want = due_reports.pop_front();
            if (got !== want)
            begin
                bad_reports++;
                if (bad_reports <= 10)
                begin
                    $display("report mismatch: expected kind %0d slot %0d t %0d x %0d y %0d",
                             want.kind, want.slot, want.t, want.x, want.y);
                    $display("    code %0d value %0d last %0d; got kind %0d slot %0d",
                             want.kcode, $signed(want.kval), want.last, got.kind, got.slot);
                    $display("    t %0d x %0d y %0d code %0d value %0d last %0d",
                             got.t, got.x, got.y, got.kcode, $signed(got.kval), got.last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot = 4'd0;
            contacts = 5'd0;
            for (int i = 0; i < SLOT_COUNT; i++)
                rows[i] = RESET_ROW;
            due_reports.delete();
            bad_reports = 0;
            due_count <= 0;
        end
        else
        begin
            if (event_valid && !event_stall)
                decode_event(event_type, event_code, event_value, time_sec, time_usec);
            if (report_valid && !report_stall)
                check_report();
            due_count <= due_reports.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the multitouch slot event decoder bench: clock, reset, event stimulus
// and report-side stalling. Needs msed_pkg, the block and touch_report_check.
module tb;
    import msed_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int HOLD_CYCLES = 200;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               event_valid  = 1'b0;
    logic               event_stall;
    logic [4:0]         event_type   = 5'd0;
    logic [9:0]         event_code   = 10'd0;
    logic signed [31:0] event_value  = 32'd0;
    logic [31:0]        time_sec     = 32'd0;
    logic [19:0]        time_usec    = 20'd0;
    logic               report_valid;
    logic               report_stall = 1'b0;
    logic [2:0]         report_kind;
    logic [3:0]         slot_index;
    logic [51:0]        time_us;
    logic [15:0]        x_pos;
    logic [15:0]        y_pos;
    logic [9:0]         key_code;
    logic signed [31:0] key_value;
    logic               last;

    int   bad_reports;
    int   due_count;
    int   items_sent  = 0;
    int   send_idle   = 0;
    int   stall_pct   = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic hold_seen   = 1'b0;

    multitouch_slot_event_decoder #(
        .SLOTS (SLOT_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_type   (event_type),
        .event_code   (event_code),
        .event_value  (event_value),
        .time_sec     (time_sec),
        .time_usec    (time_usec),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report_kind  (report_kind),
        .slot_index   (slot_index),
        .time_us      (time_us),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .key_code     (key_code),
        .key_value    (key_value),
        .last         (last)
    );

    touch_report_check #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_type   (event_type),
        .event_code   (event_code),
        .event_value  (event_value),
        .time_sec     (time_sec),
        .time_usec    (time_usec),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report_kind  (report_kind),
        .slot_index   (slot_index),
        .time_us      (time_us),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .key_code     (key_code),
        .key_value    (key_value),
        .last         (last),
        .bad_reports  (bad_reports),
        .due_count    (due_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Report side: a requested hold-off keeps the stall high while its countdown
    // runs, otherwise the stall is drawn at the current rate.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            report_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
            report_stall <= 1'b1;
        end
        else
            report_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic put_event(input logic [4:0] ty, input logic [9:0] code,
                             input logic signed [31:0] val, input logic [31:0] sec,
                             input logic [19:0] usec);
        while ($urandom_range(99) < send_idle)
        begin
            event_valid <= 1'b0;
            @(posedge clk);
        end
        event_valid <= 1'b1;
        event_type  <= ty;
        event_code  <= code;
        event_value <= val;
        time_sec    <= sec;
        time_usec   <= usec;
        @(posedge clk);
        while (event_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // The sender drops valid so that the last item is not offered again.
    // The count is registered, so it settles only after the last item has gone in.
    task automatic wait_drained();
        event_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'd0;
            2: return 32'd65535;
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic put_abs(input logic [9:0] code, input logic signed [31:0] val);
        put_event(EV_ABS, code, val, $urandom, 20'($urandom_range(999999)));
    endtask

    task automatic put_sync();
        put_event(EV_SYN, SYN_FRAME_END, $urandom, $urandom, 20'($urandom_range(999999)));
    endtask

    // One contact from selection to an optional release, with random content.
    task automatic play_gesture();
        logic signed [31:0] slot_val;
        int                 moves;
        if ($urandom_range(9) == 0)
            slot_val = $urandom;
        else
            slot_val = $urandom_range(SLOT_COUNT - 1);
        put_abs(ABS_SLOT_SELECT, slot_val);
        if ($urandom_range(9) != 0)
            put_abs(ABS_MT_TRACK, ($urandom_range(7) == 0) ? 32'h7FFF_FFFF
                                                           : $urandom_range(65535));
        put_abs(ABS_MT_POS_X, rand_coord());
        put_abs(ABS_MT_POS_Y, rand_coord());
        put_sync();
        moves = $urandom_range(4);
        for (int i = 0; i < moves; i++)
        begin
            if ($urandom_range(3) != 0)
                put_abs(ABS_MT_POS_X, rand_coord());
            if ($urandom_range(3) != 0)
                put_abs(ABS_MT_POS_Y, rand_coord());
            if ($urandom_range(7) == 0)
                put_event(EV_KEY, 10'($urandom_range(767)), $urandom, $urandom,
                          20'($urandom_range(999999)));
            put_sync();
        end
        if ($urandom_range(3) != 0)
        begin
            put_abs(ABS_MT_TRACK, ($urandom_range(1) == 0) ? -32'sd1
                                                           : ($urandom | 32'h8000_0000));
            put_sync();
            if ($urandom_range(2) == 0)
                put_sync();
        end
    endtask

    task automatic play_noise();
        logic [4:0] ty;
        logic [9:0] code;
        case ($urandom_range(3))
            0:
            begin
                ty   = 5'($urandom_range(31));
                code = 10'($urandom_range(767));
            end
            1:
            begin
                ty   = EV_ABS;
                code = 10'($urandom_range(767));
            end
            2:
            begin
                ty   = EV_KEY;
                code = ($urandom_range(1) == 0) ? KEY_CONTACT : 10'($urandom_range(767));
            end
            default:
            begin
                ty   = EV_SYN;
                code = 10'($urandom_range(767));
            end
        endcase
        put_event(ty, code, $urandom, $urandom, 20'($urandom_range(999999)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: unknown positions, key handling, ignored items,
        // slot bounds, saturation, up repeats and release at an unknown position.
        put_event(EV_SYN, SYN_FRAME_END, 32'd0, 32'd0, 20'd0);
        put_event(EV_KEY, KEY_CONTACT, 32'd1, 32'd1, 20'd1);
        put_event(EV_KEY, 10'd767, 32'h8000_0000, 32'hFFFF_FFFF, 20'd999999);
        put_event(EV_KEY, 10'd0, 32'h7FFF_FFFF, 32'd0, 20'd0);
        put_event(5'd31, 10'd767, 32'hFFFF_FFFF, 32'd2, 20'd2);
        put_event(EV_ABS, 10'd0, 32'd5, 32'd3, 20'd3);
        put_event(EV_ABS, ABS_SLOT_SELECT, -32'sd1, 32'd4, 20'd4);
        put_event(EV_ABS, ABS_SLOT_SELECT, 32'd16, 32'd5, 20'd5);
        put_event(EV_ABS, ABS_SLOT_SELECT, 32'h7FFF_FFFF, 32'd6, 20'd6);
        put_event(EV_ABS, ABS_SLOT_SELECT, 32'd15, 32'd7, 20'd7);
        put_event(EV_ABS, ABS_MT_TRACK, 32'd0, 32'hFFFF_FFFF, 20'd999999);
        put_event(EV_ABS, ABS_MT_POS_X, 32'h8000_0000, 32'd8, 20'd8);
        put_event(EV_ABS, ABS_MT_POS_Y, 32'h7FFF_FFFF, 32'd9, 20'd9);
        put_event(EV_SYN, SYN_FRAME_END, 32'd0, 32'd10, 20'd10);
        put_event(EV_ABS, ABS_MT_POS_X, 32'd70000, 32'd11, 20'd11);
        put_event(EV_SYN, SYN_FRAME_END, 32'd0, 32'd12, 20'd12);
        put_event(EV_SYN, 10'd5, 32'd0, 32'd13, 20'd13);
        put_event(EV_ABS, ABS_MT_TRACK, -32'sd1, 32'd14, 20'd14);
        put_event(EV_SYN, SYN_FRAME_END, 32'd0, 32'd15, 20'd15);
        put_event(EV_SYN, SYN_FRAME_END, 32'd0, 32'd16, 20'd16);
        put_event(EV_ABS, ABS_SLOT_SELECT, 32'd6, 32'd17, 20'd17);
        put_event(EV_ABS, ABS_MT_TRACK, -32'sd7, 32'd18, 20'd18);
        put_event(EV_ABS, ABS_MT_POS_X, 32'd100, 32'd19, 20'd19);
        put_event(EV_ABS, ABS_MT_POS_Y, 32'd200, 32'd20, 20'd20);
        put_event(EV_SYN, SYN_FRAME_END, 32'd0, 32'd21, 20'd21);
        wait_drained();

        for (int phase_no = 0; phase_no < 4; phase_no++)
        begin
            int target;
            case (phase_no)
                0:
                begin
                    send_idle = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_idle = 74;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_idle = 0;
                    stall_pct <= 74;
                end
                default:
                begin
                    send_idle = 11;
                    stall_pct <= 11;
                end
            endcase
            target = items_sent + 200;
            while (items_sent < target)
            begin
                if ($urandom_range(4) == 0)
                    play_noise();
                else
                    play_gesture();
            end
            wait_drained();
        end

        // Long report hold-off while key items keep coming, so the queue fills
        // and the event side has to stall.
        send_idle = 0;
        stall_pct <= 0;
        hold_req  <= ~hold_req;
        for (int i = 0; i < 40; i++)
            put_event(EV_KEY, 10'($urandom_range(767)), $urandom, $urandom,
                      20'($urandom_range(999999)));
        wait_drained();

        // Enough starts on one slot to saturate the contact count.
        send_idle = 11;
        stall_pct <= 11;
        put_abs(ABS_SLOT_SELECT, 32'd3);
        for (int i = 0; i < 34; i++)
            put_abs(ABS_MT_TRACK, $urandom_range(65535));
        put_abs(ABS_MT_POS_X, rand_coord());
        put_abs(ABS_MT_POS_Y, rand_coord());
        put_sync();
        put_abs(ABS_MT_TRACK, -32'sd1);
        put_sync();

        wait_drained();
        repeat (20) @(posedge clk);
        if (bad_reports == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/msed_pkg.sv
design/msed_front.sv
design/msed_queue.sv
design/msed_back.sv
design/multitouch_slot_event_decoder.sv
bench/touch_report_check.sv
bench/tb.sv
